/* rtl/core/rgb_min_filter_3x3_macros.svh */
// Assertion helpers for the RGB minimum filter.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef RGB_MIN_FILTER_3X3_MACROS_SVH
`define RGB_MIN_FILTER_3X3_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define RMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RMF_ASSERT_IMP(lbl, ante, cons, msg)
`define RMF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/rmf_pkg.sv */
package rmf_pkg;

    // Field widths fixed by the interface.
    localparam int PIX_W      = 8;
    localparam int COL_OUT_W  = 10;
    localparam int ROW_W      = 12;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int BM_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Smallest frame dimension the filter works on.
    localparam int MIN_DIM = 3;

    // Register values after reset.
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST  = FH_W'(480);
    localparam logic [BM_W-1:0] BORDER_MARGIN_RST = BM_W'(1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_BORDER_MARGIN = 2'd2
    } cfg_idx_t;

    // One RGB pixel as held in the line stores and the window.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    // One line-store entry: the row two back and the previous row.
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
    } line_pair_t;

    // Input beat.
    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } pix_in_t;

    // Result beat.
    typedef struct packed {
        logic [COL_OUT_W-1:0] center_col;
        logic [ROW_W-1:0]     center_row;
        logic [PIX_W-1:0]     red_min;
        logic [PIX_W-1:0]     green_min;
        logic [PIX_W-1:0]     blue_min;
    } res_t;

endpackage

/* rtl/core/rmf_line_mem.sv */
module rmf_line_mem
    import rmf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data is held until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/rmf_min9.sv */
module rmf_min9
    import rmf_pkg::*;
(
    input  pixel_t win [9],
    output pixel_t min_pix
);

    logic [PIX_W-1:0] red_v   [9];
    logic [PIX_W-1:0] green_v [9];
    logic [PIX_W-1:0] blue_v  [9];

    // Four-level compare tree over nine values.
    function automatic logic [PIX_W-1:0] min_of9(input logic [PIX_W-1:0] v [9]);
        logic [PIX_W-1:0] l1 [4];
        logic [PIX_W-1:0] l2 [2];
        logic [PIX_W-1:0] l3;
        for (int i = 0; i < 4; i++)
        begin
            l1[i] = (v[2*i] < v[2*i+1]) ? v[2*i] : v[2*i+1];
        end
        for (int i = 0; i < 2; i++)
        begin
            l2[i] = (l1[2*i] < l1[2*i+1]) ? l1[2*i] : l1[2*i+1];
        end
        l3 = (l2[0] < l2[1]) ? l2[0] : l2[1];
        return (l3 < v[8]) ? l3 : v[8];
    endfunction

    // Split the window into channels.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            red_v[i]   = win[i].red;
            green_v[i] = win[i].green;
            blue_v[i]  = win[i].blue;
        end
    end

    // Each channel is reduced on its own.
    always_comb
    begin
        min_pix.red   = min_of9(red_v);
        min_pix.green = min_of9(green_v);
        min_pix.blue  = min_of9(blue_v);
    end

endmodule

/* rtl/core/rgb_min_filter_3x3.sv */
// A result is written into the output register as its pixel beat leaves stage 1;
// the beat waits in stage 1 only while the output register holds a stalled result.
// Throughput: one pixel per cycle; the line-store memory is read and written in
// the same cycle at different columns, and pixels wait only on a stalled output.
// Reset: counters, window registers and the output valid flag clear, and the
// configuration registers load their defaults; the line stores are not cleared.
`include "rgb_min_filter_3x3_macros.svh"

module rgb_min_filter_3x3
    import rmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pix_in_t               pix,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_t                  res
);

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = ((WW > ROW_W) ? WW : ROW_W) + 2;

    // Configuration registers.
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [BM_W-1:0] border_margin_reg;

    // Raster position of the next pixel.
    logic [CW-1:0]    col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    // Stage 1: pixel waiting for its line-store read.
    logic                 s1_valid_reg;
    logic                 s1_emit_reg;
    pixel_t               s1_pix_reg;
    logic [CW-1:0]        s1_col_reg;
    logic [COL_OUT_W-1:0] s1_ccol_reg;
    logic [ROW_W-1:0]     s1_crow_reg;

    // Two earlier columns of the window.
    pixel_t win_reg [6];

    // Output register.
    logic res_valid_reg;
    res_t res_reg;

    logic pix_accept, res_free, s1_adv;
    logic [CMPW-1:0] w_eff, h_eff, m_eff, c_eff, r_eff, c_inc, r_inc, c_m1, r_m1;
    logic emit0;
    line_pair_t rd_pair, wr_pair;
    pixel_t win_all [9];
    pixel_t min_pix;

    // Handshake.
    assign pix_accept = pix_valid & ~pix_stall;
    assign res_free   = ~res_valid_reg | ~res_stall;
    assign s1_adv     = s1_valid_reg & res_free;
    assign pix_stall  = s1_valid_reg & ~res_free;

    // Effective frame geometry and current position.
    always_comb
    begin
        w_eff = CMPW'(frame_width_reg);
        if (w_eff < CMPW'(MIN_DIM))
        begin
            w_eff = CMPW'(MIN_DIM);
        end
        else if (w_eff > CMPW'(MAX_WIDTH))
        begin
            w_eff = CMPW'(MAX_WIDTH);
        end
        h_eff = CMPW'(frame_height_reg);
        if (h_eff < CMPW'(MIN_DIM))
        begin
            h_eff = CMPW'(MIN_DIM);
        end
        m_eff = CMPW'(border_margin_reg);
        if (m_eff == '0)
        begin
            m_eff = CMPW'(1);
        end
        c_eff = CMPW'(col_count_reg);
        if (c_eff >= w_eff)
        begin
            c_eff = '0;
        end
        r_eff = CMPW'(row_count_reg);
        if (r_eff >= h_eff)
        begin
            r_eff = '0;
        end
    end

    // Window center lies inside the frame less the margin.
    always_comb
    begin
        emit0 = (c_eff >= m_eff + CMPW'(1)) && (c_eff + m_eff <= w_eff) &&
                (r_eff >= m_eff + CMPW'(1)) && (r_eff + m_eff <= h_eff);
        c_m1  = c_eff - CMPW'(1);
        r_m1  = r_eff - CMPW'(1);
    end

    // Next raster position with row and frame wrap.
    always_comb
    begin
        c_inc = c_eff + CMPW'(1);
        r_inc = r_eff + CMPW'(1);
        if (c_inc >= w_eff)
        begin
            col_count_next = '0;
            row_count_next = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            col_count_next = c_inc[CW-1:0];
            row_count_next = r_eff[ROW_W-1:0];
        end
    end

    // Configuration writes; any write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FRAME_WIDTH_RST;
            frame_height_reg  <= FRAME_HEIGHT_RST;
            border_margin_reg <= BORDER_MARGIN_RST;
            col_count_reg     <= '0;
            row_count_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata[FH_W-1:0];
                CFG_BORDER_MARGIN: border_margin_reg <= cfg_wdata[BM_W-1:0];
                default:           ;
            endcase
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (pix_accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // Stage 1 valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload.
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_emit_reg       <= emit0;
            s1_pix_reg.red    <= pix.red_in;
            s1_pix_reg.green  <= pix.green_in;
            s1_pix_reg.blue   <= pix.blue_in;
            s1_col_reg        <= c_eff[CW-1:0];
            s1_ccol_reg       <= c_m1[COL_OUT_W-1:0];
            s1_crow_reg       <= r_m1[ROW_W-1:0];
        end
    end

    // Line stores: read at the new pixel's column, written back as it leaves stage 1.
    assign wr_pair.top = rd_pair.mid;
    assign wr_pair.mid = s1_pix_reg;

    rmf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    ($bits(line_pair_t))
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (pix_accept),
        .rd_addr (c_eff[CW-1:0]),
        .rd_data (rd_pair),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (wr_pair)
    );

    // Full 3x3 window for the pixel in stage 1.
    always_comb
    begin
        win_all[0] = rd_pair.top;
        win_all[1] = rd_pair.mid;
        win_all[2] = s1_pix_reg;
        for (int i = 0; i < 6; i++)
        begin
            win_all[i+3] = win_reg[i];
        end
    end

    rmf_min9 u_min9 (
        .win     (win_all),
        .min_pix (min_pix)
    );

    // Window column shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= rd_pair.top;
            win_reg[1] <= rd_pair.mid;
            win_reg[2] <= s1_pix_reg;
        end
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            res_valid_reg <= s1_emit_reg;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            res_reg.center_col <= s1_ccol_reg;
            res_reg.center_row <= s1_crow_reg;
            res_reg.red_min    <= min_pix.red;
            res_reg.green_min  <= min_pix.green;
            res_reg.blue_min   <= min_pix.blue;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Checks.
    `RMF_ASSERT_IMP(a_stall_only_when_full, pix_stall,
        s1_valid_reg && res_valid_reg && res_stall,
        "input stalled while the pipeline can move")
    `RMF_ASSERT_IMP(a_emit_col_nonzero, s1_valid_reg && s1_emit_reg,
        s1_col_reg != '0,
        "result scheduled for a window at the left edge")
    `RMF_ASSERT_NEXT(a_emit_reaches_out, s1_adv && s1_emit_reg, res_valid_reg,
        "window result did not reach the output register")

endmodule
